FILE: hw/rtl/utf_pkg.sv
// Package for the UART transmitter with transmit FIFO.
// Holds sizes, command codes and the request and result types.
// No dependencies; every other file of the block uses it.
package utf_pkg;

  // Transmit FIFO geometry.
  localparam int FifoDepth = 16;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  // 8N1 frame layout: position 0 is start, 1..8 data, 9 and above stop.
  localparam int DataBits = 8;
  localparam int BitPosW  = 4;

  // Request queue between the front and the back.
  localparam int QueueDepth = 2;
  localparam int QIdxW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_PUSH = 1'b1;

  // A classified request.
  typedef struct packed {
    logic                is_push;
    logic [DataBits-1:0] data;
  } cmd_t;

  // One result.
  typedef struct packed {
    logic       tx_line;
    logic       busy_res;
    logic [4:0] fifo_count;
    logic       push_dropped;
  } res_t;

endpackage

FILE: hw/rtl/utf_if.sv
// Valid/ready channel interfaces of the UART transmitter.
// Depends on utf_pkg for the data width.
interface utf_req_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [utf_pkg::DataBits-1:0] tx_byte;

  modport source (output valid, output command, output tx_byte, input ready);
  modport sink   (input valid, input command, input tx_byte, output ready);
endinterface

interface utf_res_if;
  logic       valid;
  logic       ready;
  logic       tx_line;
  logic       busy_res;
  logic [4:0] fifo_count;
  logic       push_dropped;

  modport source (output valid, output tx_line, output busy_res, output fifo_count,
                  output push_dropped, input ready);
  modport sink   (input valid, input tx_line, input busy_res, input fifo_count,
                  input push_dropped, output ready);
endinterface

FILE: hw/rtl/utf_cmd_queue.sv
// Front of the UART transmitter: classifies requests and holds them in a
// short queue for the back end. Depends on utf_pkg.
module utf_cmd_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic                         req_command_i,
  input  logic [utf_pkg::DataBits-1:0] req_byte_i,
  output logic                         req_ready_o,
  output logic                         cmd_valid_o,
  output utf_pkg::cmd_t                cmd_o,
  input  logic                         cmd_ready_i
);

  utf_pkg::cmd_t                    entry_q [utf_pkg::QueueDepth];
  logic [utf_pkg::QIdxW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [utf_pkg::QIdxW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [utf_pkg::QCntW-1:0]        count_q, count_d;
  logic                             push, pop;
  utf_pkg::cmd_t                    cmd_in;

  assign cmd_in.is_push = (req_command_i == utf_pkg::CMD_PUSH);
  assign cmd_in.data    = req_byte_i;

  assign req_ready_o = (count_q != utf_pkg::QCntW'(utf_pkg::QueueDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];

  assign push = req_valid_i && req_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == utf_pkg::QIdxW'(utf_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == utf_pkg::QIdxW'(utf_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: hw/rtl/utf_engine.sv
// UART transmitter back end: transmit FIFO, 8N1 serializer, result register.
// Executes one queued request per cycle unless stalled. Depends on utf_pkg.
module utf_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  utf_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  output logic          res_valid_o,
  output utf_pkg::res_t res_o,
  input  logic          res_ready_i
);

  logic [utf_pkg::DataBits-1:0] fifo_mem [utf_pkg::FifoDepth];
  logic [utf_pkg::PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [utf_pkg::PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [utf_pkg::CntW-1:0]     count_q, count_d;
  logic                         sending_q, sending_d;
  logic [utf_pkg::BitPosW-1:0]  bit_pos_q, bit_pos_d;
  logic [utf_pkg::DataBits-1:0] shift_q, shift_d;
  logic                         line_q, line_d;
  logic                         dropped;
  logic                         fifo_we;
  logic                         fifo_re;
  logic                         fire;
  logic                         res_valid_q;
  utf_pkg::res_t                res_q;

  localparam logic [utf_pkg::PtrW-1:0] PtrLast = utf_pkg::PtrW'(utf_pkg::FifoDepth - 1);
  localparam logic [utf_pkg::CntW-1:0] CntFull = utf_pkg::CntW'(utf_pkg::FifoDepth);

  // The result register frees up in the same cycle it is taken.
  assign cmd_ready_o = !res_valid_q || res_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    count_d   = count_q;
    sending_d = sending_q;
    bit_pos_d = bit_pos_q;
    shift_d   = shift_q;
    line_d    = line_q;
    dropped   = 1'b0;
    fifo_we   = 1'b0;
    fifo_re   = 1'b0;
    if (fire) begin
      if (cmd_i.is_push) begin
        if (count_q == CntFull) begin
          dropped = 1'b1;
        end else begin
          fifo_we  = 1'b1;
          wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
          count_d  = count_q + 1'b1;
        end
        sending_d = 1'b1;
      end else if (sending_q) begin
        if (bit_pos_q == '0) begin
          // Start bit, or nothing left to send. The popped byte is loaded
          // into the shift register at the clock edge.
          if (count_q != '0) begin
            fifo_re   = 1'b1;
            line_d    = 1'b0;
            bit_pos_d = utf_pkg::BitPosW'(1);
            rd_ptr_d  = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
            count_d   = count_q - 1'b1;
          end else begin
            line_d    = 1'b1;
            sending_d = 1'b0;
          end
        end else if (bit_pos_q <= utf_pkg::BitPosW'(utf_pkg::DataBits)) begin
          line_d    = shift_q[0];
          shift_d   = shift_q >> 1;
          bit_pos_d = bit_pos_q + 1'b1;
        end else begin
          // Stop bit; any position past the last data bit lands here.
          line_d    = 1'b1;
          bit_pos_d = '0;
          if (count_q == '0) begin
            sending_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      sending_q   <= 1'b0;
      bit_pos_q   <= '0;
      shift_q     <= '0;
      line_q      <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      count_q   <= count_d;
      sending_q <= sending_d;
      bit_pos_q <= bit_pos_d;
      shift_q   <= fifo_re ? fifo_mem[rd_ptr_q] : shift_d;
      line_q    <= line_d;
      if (fire) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[wr_ptr_q] <= cmd_i.data;
    end
    if (fire) begin
      res_q.tx_line      <= line_d;
      res_q.busy_res     <= sending_d;
      res_q.fifo_count   <= 5'(count_d);
      res_q.push_dropped <= dropped;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: hw/rtl/uart_transmitter_with_fifo_unit.sv
// Top level of the 8N1 UART transmitter with a transmit FIFO.
// Depends on utf_pkg, utf_if, utf_cmd_queue and utf_engine.
//
//   Channel  Dir  Modport  Payload
//   req_i    in   sink     command, tx_byte
//   res_o    out  source   tx_line, busy_res, fifo_count, push_dropped
//
// One request per cycle is sustained while results are taken; each request
// passes through the request queue, then the engine's result register.
// The engine owns the result register and executes one request per cycle
// while it is free or being taken. Reset clears the pointers, counters and
// serializer; FIFO entries are not cleared. A stalled result register backs
// up into the two-entry request queue, which then lowers req_i.ready.
module uart_transmitter_with_fifo_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  utf_req_if.sink      req_i,
  utf_res_if.source    res_o
);

  logic          cmd_valid;
  logic          cmd_ready;
  utf_pkg::cmd_t cmd;
  logic          res_valid;
  utf_pkg::res_t res;

  utf_cmd_queue u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_command_i (req_i.command),
    .req_byte_i    (req_i.tx_byte),
    .req_ready_o   (req_i.ready),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_ready_i   (cmd_ready)
  );

  utf_engine u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_o.ready)
  );

  assign res_o.valid        = res_valid;
  assign res_o.tx_line      = res.tx_line;
  assign res_o.busy_res     = res.busy_res;
  assign res_o.fifo_count   = res.fifo_count;
  assign res_o.push_dropped = res.push_dropped;

`ifndef SYNTHESIS
  // The FIFO never reports more entries than it holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res.fifo_count <= 5'(utf_pkg::FifoDepth)))
    else $error("fifo_count exceeds FIFO depth");

  // When the sender is idle nothing may be waiting in the FIFO.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res.busy_res) |-> (res.fifo_count == '0))
    else $error("idle sender with queued bytes");

  // The line is only driven low inside a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res.tx_line) |-> res.busy_res)
    else $error("line low while sender idle");

  // A dropped request means a full FIFO and a busy sender.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.push_dropped) |->
      (res.busy_res && (res.fifo_count == 5'(utf_pkg::FifoDepth))))
    else $error("request dropped without a full FIFO");
`endif

endmodule
